@@ hw/rtl/sacrr_pkg.sv @@
// ----------------------------------------------------------------------------
// sacrr_pkg
// Shared constants, types and helpers of the set-associative cache core.
// ----------------------------------------------------------------------------
`default_nettype none

package sacrr_pkg;

  // geometry
  localparam int NUM_SETS   = 128;
  localparam int NUM_WAYS   = 8;
  localparam int LINE_BYTES = 64;

  localparam int ADDR_W = 32;
  localparam int BYTE_W = 8;
  localparam int OP_W   = 2;
  localparam int OFF_W  = $clog2(LINE_BYTES);
  localparam int SET_W  = $clog2(NUM_SETS);
  localparam int WAY_W  = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
  localparam int TAG_W  = ADDR_W - OFF_W - SET_W;

  // data store index is {set, way, offset}
  localparam int DATA_AW    = SET_W + WAY_W + OFF_W;
  localparam int DATA_DEPTH = 1 << DATA_AW;

  // result field widths
  localparam int LINE_ADDR_W = 26;
  localparam int WAY_OUT_W   = 3;

  localparam int IN_DATA_W  = 40;  // address, data_byte
  localparam int OUT_DATA_W = 40;  // hit, read_byte, fill_needed, line_address, way_used

  // victim LFSR (Galois, shift right)
  localparam int             LFSR_W    = 8;
  localparam logic [LFSR_W-1:0] LFSR_TAPS = 8'hB8;
  localparam logic [LFSR_W-1:0] LFSR_SEED = 8'h01;

  // opcodes
  localparam logic [OP_W-1:0] OP_READ  = 2'd0;
  localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
  localparam logic [OP_W-1:0] OP_FILL  = 2'd2;

  // one row of the tag store: valid mask and the tags of every way
  typedef struct packed {
    logic [NUM_WAYS-1:0]             valid;
    logic [NUM_WAYS-1:0][TAG_W-1:0]  tag;
  } row_t;

  // lookup outcome handed from the tag store to the control
  typedef struct packed {
    logic             hit;    // valid way matched (read, write or fill)
    logic             alloc;  // read/write miss, line allocated
    logic [WAY_W-1:0] way;    // way that hit or was allocated
  } lookup_t;

  // lfsr modulo NUM_WAYS; the way count is a power of two, so this is a mask
  function automatic logic [WAY_W-1:0] victim_way(input logic [LFSR_W-1:0] l);
    return WAY_W'(l % LFSR_W'(NUM_WAYS));
  endfunction

  function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] l);
    logic [LFSR_W-1:0] s;
    s = l >> 1;
    if (l[0]) begin
      s = s ^ LFSR_TAPS;
    end
    return s;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/set_assoc_cache_random_replace_core.sv @@
// ----------------------------------------------------------------------------
// set_assoc_cache_random_replace_core
// Write-through set-associative cache with LFSR victim choice.
// ----------------------------------------------------------------------------
// Usage:
//   Input items (in_*) carry an opcode in in_tuser (read, write or fill byte)
//   and {data_byte, address} in in_tdata. Every item gives exactly one result
//   item on out_*: hit flag, read byte, fill request, line address and way.
//   A read/write miss allocates a way and sets fill_needed; the environment
//   then sends the line's bytes as fill items.
//   Timing: the tag row is read on the accepting edge; the next cycle does
//   the compare, the tag write back and the data access, and S_DATA then
//   loads the output register and out_tvalid once it is free. Items are
//   taken one at a time; the next one is accepted only after the output
//   register has been loaded. in_tready is high whenever no item is in
//   flight, also while a finished result sits in the output register. If
//   the receiver stalls, the next item waits in its last stage until the
//   output register frees up.
//   Reset clears all valid bits at once (per-set flags) and reloads the LFSR
//   seed; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module set_assoc_cache_random_replace_core (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  input  wire logic [sacrr_pkg::IN_DATA_W-1:0]    in_tdata,   // address[31:0], data_byte[39:32]
  input  wire logic [sacrr_pkg::OP_W-1:0]         in_tuser,   // opcode[1:0]
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  output logic      [sacrr_pkg::OUT_DATA_W-1:0]   out_tdata   // hit[0], read_byte[8:1],
                                                              // fill_needed[9],
                                                              // line_address[35:10],
                                                              // way_used[38:36], pad[39]
);
  import sacrr_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_TAG  = 2'd1;
  localparam logic [1:0] S_DATA = 2'd2;

  logic [1:0]             state_r, state_nxt;
  logic [OP_W-1:0]        op_r;
  logic [ADDR_W-1:0]      addr_r;
  logic [BYTE_W-1:0]      byte_r;

  logic                   rd_hit_r;
  logic                   res_hit_r;
  logic                   res_fill_r;
  logic [LINE_ADDR_W-1:0] res_line_r;
  logic [WAY_OUT_W-1:0]   res_way_r;

  logic                   out_tvalid_r;
  logic                   out_hit_r;
  logic [BYTE_W-1:0]      out_byte_r;
  logic                   out_fill_r;
  logic [LINE_ADDR_W-1:0] out_line_r;
  logic [WAY_OUT_W-1:0]   out_way_r;

  logic                   in_accept;
  logic                   out_free;
  logic                   in_tag_st;
  lookup_t                lk;
  logic [SET_W-1:0]       cur_set;
  logic [OFF_W-1:0]       cur_off;
  logic [TAG_W-1:0]       cur_tag;
  logic                   d_en;
  logic                   d_we;
  logic [DATA_AW-1:0]     d_addr;
  logic [BYTE_W-1:0]      d_rdata;

  assign in_tready = (state_r == S_IDLE);
  assign in_accept = in_tvalid && in_tready;
  assign out_free  = !out_tvalid_r || out_tready;
  assign in_tag_st = (state_r == S_TAG);

  assign cur_off = addr_r[OFF_W-1:0];
  assign cur_set = addr_r[OFF_W +: SET_W];
  assign cur_tag = addr_r[ADDR_W-1 -: TAG_W];

  sacrr_tag_store u_tag (
    .clk    (clk),
    .rst_n  (rst_n),
    .rd_en  (in_accept),
    .rd_set (in_tdata[OFF_W +: SET_W]),
    .lk_en  (in_tag_st),
    .lk_op  (op_r),
    .lk_tag (cur_tag),
    .lk     (lk)
  );

  // data access only on a hit; write-through writes never touch an allocated line
  assign d_en   = in_tag_st && lk.hit;
  assign d_we   = (op_r == OP_WRITE) || (op_r == OP_FILL);
  assign d_addr = {cur_set, lk.way, cur_off};

  sacrr_data_store u_data (
    .clk   (clk),
    .en    (d_en),
    .we    (d_we),
    .addr  (d_addr),
    .wdata (byte_r),
    .rdata (d_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          state_nxt = S_TAG;
        end
      end
      S_TAG: begin
        state_nxt = S_DATA;
      end
      S_DATA: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // item payload and lookup results
  always_ff @(posedge clk) begin
    if (in_accept) begin
      op_r   <= in_tuser;
      addr_r <= in_tdata[ADDR_W-1:0];
      byte_r <= in_tdata[ADDR_W +: BYTE_W];
    end
    if (in_tag_st) begin
      rd_hit_r   <= lk.hit && (op_r == OP_READ);
      res_hit_r  <= lk.hit;
      res_fill_r <= lk.alloc;
      res_line_r <= lk.alloc ? LINE_ADDR_W'(addr_r >> OFF_W) : '0;
      res_way_r  <= (lk.hit || lk.alloc) ? WAY_OUT_W'(lk.way) : '0;
    end
    if ((state_r == S_DATA) && out_free) begin
      out_hit_r  <= res_hit_r;
      out_byte_r <= rd_hit_r ? d_rdata : '0;
      out_fill_r <= res_fill_r;
      out_line_r <= res_line_r;
      out_way_r  <= res_way_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if ((state_r == S_DATA) && out_free) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {1'b0, out_way_r, out_line_r, out_fill_r, out_byte_r, out_hit_r};

`ifndef SYNTHESIS
  a_result_from_data_stage: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> $past(state_r) == S_DATA)
    else $error("result appeared without a finished item");

  a_hit_excludes_fill: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r |-> !(out_hit_r && out_fill_r))
    else $error("result reports both hit and fill request");

  a_lookup_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    in_tag_st |-> !(lk.hit && lk.alloc))
    else $error("lookup both hit and allocated");

  a_byte_only_on_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && (out_byte_r != '0)) |-> out_hit_r)
    else $error("read byte returned without a hit");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/sacrr_data_store.sv @@
// ----------------------------------------------------------------------------
// sacrr_data_store
// Byte-wide line data memory, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sacrr_data_store (
  input  wire logic                         clk,
  input  wire logic                         en,
  input  wire logic                         we,
  input  wire logic [sacrr_pkg::DATA_AW-1:0] addr,
  input  wire logic [sacrr_pkg::BYTE_W-1:0]  wdata,
  output logic      [sacrr_pkg::BYTE_W-1:0]  rdata
);
  import sacrr_pkg::*;

  logic [BYTE_W-1:0] mem [DATA_DEPTH];
  logic [BYTE_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata_r <= mem[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

@@ hw/rtl/sacrr_tag_store.sv @@
// ----------------------------------------------------------------------------
// sacrr_tag_store
// Tag/valid memory (one row per set), tag compare, way allocation and the
// victim LFSR. A row is read on rd_en and rewritten on an allocating lk_en.
// ----------------------------------------------------------------------------
`default_nettype none

module sacrr_tag_store (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        rd_en,
  input  wire logic [sacrr_pkg::SET_W-1:0] rd_set,
  input  wire logic                        lk_en,
  input  wire logic [sacrr_pkg::OP_W-1:0]  lk_op,
  input  wire logic [sacrr_pkg::TAG_W-1:0] lk_tag,
  output sacrr_pkg::lookup_t               lk
);
  import sacrr_pkg::*;

  row_t                tag_mem [NUM_SETS];
  row_t                row_r;
  logic [SET_W-1:0]    set_r;
  // per-row written flag: a row never written reads as all ways invalid
  logic [NUM_SETS-1:0] row_init_r;
  logic                init_r;
  logic [LFSR_W-1:0]   lfsr_r;

  logic [NUM_WAYS-1:0] valid;
  logic [NUM_WAYS-1:0] match;
  logic [WAY_W-1:0]    hit_way;
  logic [WAY_W-1:0]    free_way;
  logic                any_hit;
  logic                full;
  logic                is_rw;
  logic                is_fill;
  row_t                row_wr;

  always_comb begin
    valid    = init_r ? row_r.valid : '0;
    hit_way  = '0;
    free_way = '0;
    for (int w = 0; w < NUM_WAYS; w++) begin
      match[w] = valid[w] && (row_r.tag[w] == lk_tag);
    end
    // lowest matching / lowest free way wins
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      if (match[w]) begin
        hit_way = WAY_W'(w);
      end
      if (!valid[w]) begin
        free_way = WAY_W'(w);
      end
    end
    any_hit = |match;
    full    = &valid;
    is_rw   = (lk_op == OP_READ) || (lk_op == OP_WRITE);
    is_fill = (lk_op == OP_FILL);

    lk.hit   = (is_rw || is_fill) && any_hit;
    lk.alloc = is_rw && !any_hit;
    if (any_hit) begin
      lk.way = hit_way;
    end else if (full) begin
      lk.way = victim_way(lfsr_r);
    end else begin
      lk.way = free_way;
    end

    row_wr              = row_r;
    row_wr.valid        = valid;
    row_wr.valid[lk.way] = 1'b1;
    row_wr.tag[lk.way]   = lk_tag;
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      row_r <= tag_mem[rd_set];
      set_r <= rd_set;
    end
    if (lk_en && lk.alloc) begin
      tag_mem[set_r] <= row_wr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_init_r <= '0;
      init_r     <= 1'b0;
      lfsr_r     <= LFSR_SEED;
    end else begin
      if (rd_en) begin
        init_r <= row_init_r[rd_set];
      end
      if (lk_en && lk.alloc) begin
        row_init_r[set_r] <= 1'b1;
        if (full) begin
          lfsr_r <= lfsr_step(lfsr_r);
        end
      end
    end
  end

endmodule

`default_nettype wire
